FILE: design/descending_merge_sorter_unit_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the descending merge sorter checker.
// ----------------------------------------------------------------------------
`ifndef DESCENDING_MERGE_SORTER_UNIT_MACROS_SVH
`define DESCENDING_MERGE_SORTER_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define DMSU_ASSERT_IMPLY(label, clk, rst_n, lhs, rhs) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |-> (rhs)) \
        else $error("descending merge sorter check failed");

// Next-cycle implication, disabled while reset is asserted.
`define DMSU_ASSERT_NEXT(label, clk, rst_n, lhs, rhs) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |=> (rhs)) \
        else $error("descending merge sorter check failed");

`endif

FILE: design/dmsu_pkg.sv
// ----------------------------------------------------------------------------
// dmsu_pkg
// Shared constants and types of the descending merge sorter.
// ----------------------------------------------------------------------------
`default_nettype none

package dmsu_pkg;

    // Capacity of one set and width of the stored keys.
    localparam int MAX_ITEMS    = 64;
    localparam int KEY_BITS     = 32;
    localparam int IN_KEY_BITS  = 32;
    localparam int OUT_KEY_BITS = 32;
    localparam int OUT_POS_BITS = 6;

    // Derived widths.
    localparam int POS_BITS = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
    localparam int CNT_BITS = $clog2(MAX_ITEMS + 1);

    // One stored record of a cell.
    typedef struct packed {
        logic                valid;
        logic [KEY_BITS-1:0] key;
        logic [POS_BITS-1:0] pos;
    } entry_t;

    // Commands broadcast to every cell of the chain.
    typedef struct packed {
        logic insert;
        logic pop;
    } cell_ctrl_t;

    // Controller states.
    typedef enum logic {
        ST_LOAD,
        ST_DRAIN
    } state_t;

endpackage

`default_nettype wire

FILE: design/dmsu_if.sv
// ----------------------------------------------------------------------------
// dmsu_if
// Valid/ready channels for loading keys and returning sorted results.
// ----------------------------------------------------------------------------
`default_nettype none

// Load channel: one sort key per item.
interface dmsu_in_if;
    logic                               valid;
    logic                               ready;
    logic [dmsu_pkg::IN_KEY_BITS-1:0]   key;
    logic                               last;

    modport source (output valid, output key, output last, input ready);
    modport sink   (input valid, input key, input last, output ready);
endinterface

// Result channel: one sorted record per item.
interface dmsu_out_if;
    logic                               valid;
    logic                               ready;
    logic [dmsu_pkg::OUT_KEY_BITS-1:0]  key_out;
    logic [dmsu_pkg::OUT_POS_BITS-1:0]  position;
    logic                               overflow;
    logic                               last_out;

    modport source (output valid, output key_out, output position,
                    output overflow, output last_out, input ready);
    modport sink   (input valid, input key_out, input position,
                    input overflow, input last_out, output ready);
endinterface

`default_nettype wire

FILE: design/dmsu_cell.sv
// ----------------------------------------------------------------------------
// dmsu_cell
// One cell of the sorting chain: holds one record, inserts or shifts.
// ----------------------------------------------------------------------------
`default_nettype none

module dmsu_cell (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire dmsu_pkg::cell_ctrl_t          ctrl,
    input  wire logic [dmsu_pkg::KEY_BITS-1:0] new_key,
    input  wire logic [dmsu_pkg::POS_BITS-1:0] new_pos,
    input  wire dmsu_pkg::entry_t              up,
    input  wire logic                          up_take,
    input  wire dmsu_pkg::entry_t              down,
    output dmsu_pkg::entry_t                   entry,
    output logic                               take
);

    logic                          valid_reg;
    logic                          valid_next;
    logic [dmsu_pkg::KEY_BITS-1:0] key_reg;
    logic [dmsu_pkg::KEY_BITS-1:0] key_next;
    logic [dmsu_pkg::POS_BITS-1:0] pos_reg;
    logic [dmsu_pkg::POS_BITS-1:0] pos_next;

    // The new item belongs at or before this cell when the cell is empty or
    // holds a key no larger; equal keys put the later arrival first.
    assign take = !valid_reg || (new_key >= key_reg);

    // Next record: pull from below when draining, else shift down or insert.
    always_comb
    begin
        valid_next = valid_reg;
        key_next   = key_reg;
        pos_next   = pos_reg;
        if (ctrl.pop)
        begin
            valid_next = down.valid;
            key_next   = down.key;
            pos_next   = down.pos;
        end
        else if (ctrl.insert)
        begin
            if (up_take)
            begin
                valid_next = up.valid;
                key_next   = up.key;
                pos_next   = up.pos;
            end
            else if (take)
            begin
                valid_next = 1'b1;
                key_next   = new_key;
                pos_next   = new_pos;
            end
        end
    end

    // Occupancy flag is control state and is cleared at reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Record payload.
    always_ff @(posedge clk)
    begin
        key_reg <= key_next;
        pos_reg <= pos_next;
    end

    assign entry.valid = valid_reg;
    assign entry.key   = key_reg;
    assign entry.pos   = pos_reg;

endmodule

`default_nettype wire

FILE: design/descending_merge_sorter_unit.sv
// ----------------------------------------------------------------------------
// descending_merge_sorter_unit
// Sorts a set of up to 64 keys into descending order with a chain of cells.
// ----------------------------------------------------------------------------
// Usage:
// Keys enter on the load channel, one item per cycle while ready is high.
// Each key is tagged with its arrival position and inserted straight into
// its sorted place in a row of 64 cells. Items beyond 64 are dropped and
// set the overflow flag of the set. The item with last set ends the set.
// Load ready then drops and the set drains from the head cell into an
// output register, one result per cycle while the receiver is ready,
// largest key first; equal keys come out latest arrival first. The final
// result carries last_out. The first result is popped once the drain
// state is entered and the output register is free. A set is loaded in
// full and then drained through the single port at the head cell.
// Loading of the next set starts once every cell has been emptied, while
// the final result may still wait in the output register.
// A stalled receiver holds the output register and freezes the chain.
// Reset empties every cell and clears the count and the overflow flag.
// ----------------------------------------------------------------------------
`default_nettype none

module descending_merge_sorter_unit (
    input  wire logic       clk,
    input  wire logic       rst_n,
    dmsu_in_if.sink         load,
    dmsu_out_if.source      result
);

    dmsu_pkg::state_t              state_reg;
    dmsu_pkg::state_t              state_next;
    logic [dmsu_pkg::CNT_BITS-1:0] count_reg;
    logic [dmsu_pkg::CNT_BITS-1:0] count_next;
    logic                          overflowed_reg;
    logic                          overflowed_next;

    logic                              out_valid_reg;
    logic                              out_valid_next;
    logic [dmsu_pkg::OUT_KEY_BITS-1:0] out_key_reg;
    logic [dmsu_pkg::OUT_POS_BITS-1:0] out_pos_reg;
    logic                              out_ovf_reg;
    logic                              out_last_reg;

    dmsu_pkg::cell_ctrl_t          ctrl;
    dmsu_pkg::entry_t              entries [dmsu_pkg::MAX_ITEMS];
    logic [dmsu_pkg::MAX_ITEMS-1:0] takes;
    logic [dmsu_pkg::KEY_BITS-1:0] new_key;
    logic [dmsu_pkg::POS_BITS-1:0] new_pos;
    logic                          load_acc;
    logic                          room;
    logic                          out_free;

    assign load_acc = load.valid && load.ready;
    assign room     = (count_reg < dmsu_pkg::CNT_BITS'(dmsu_pkg::MAX_ITEMS));
    assign out_free = !out_valid_reg || result.ready;
    assign new_key  = dmsu_pkg::KEY_BITS'(load.key);
    assign new_pos  = count_reg[dmsu_pkg::POS_BITS-1:0];

    // Chain of cells; cell zero holds the largest record.
    for (genvar i = 0; i < dmsu_pkg::MAX_ITEMS; i++)
    begin : g_cell
        dmsu_pkg::entry_t up_entry;
        dmsu_pkg::entry_t down_entry;
        logic             up_take;

        if (i == 0)
        begin : g_head
            assign up_entry = '0;
            assign up_take  = 1'b0;
        end
        else
        begin : g_body
            assign up_entry = entries[i-1];
            assign up_take  = takes[i-1];
        end

        if (i == dmsu_pkg::MAX_ITEMS - 1)
        begin : g_tail
            assign down_entry = '0;
        end
        else
        begin : g_inner
            assign down_entry = entries[i+1];
        end

        dmsu_cell u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .ctrl    (ctrl),
            .new_key (new_key),
            .new_pos (new_pos),
            .up      (up_entry),
            .up_take (up_take),
            .down    (down_entry),
            .entry   (entries[i]),
            .take    (takes[i])
        );
    end

    // Load and drain sequencing.
    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        overflowed_next = overflowed_reg;
        out_valid_next  = out_valid_reg;
        ctrl            = '0;
        load.ready      = 1'b0;
        unique case (state_reg)
            dmsu_pkg::ST_LOAD:
            begin
                load.ready = 1'b1;
                if (result.ready)
                begin
                    out_valid_next = 1'b0;
                end
                if (load_acc)
                begin
                    if (room)
                    begin
                        ctrl.insert = 1'b1;
                        count_next  = count_reg + dmsu_pkg::CNT_BITS'(1);
                    end
                    else
                    begin
                        overflowed_next = 1'b1;
                    end
                    if (load.last)
                    begin
                        state_next = dmsu_pkg::ST_DRAIN;
                    end
                end
            end
            dmsu_pkg::ST_DRAIN:
            begin
                if (out_free)
                begin
                    ctrl.pop       = 1'b1;
                    out_valid_next = 1'b1;
                    count_next     = count_reg - dmsu_pkg::CNT_BITS'(1);
                    if (count_reg == dmsu_pkg::CNT_BITS'(1))
                    begin
                        state_next      = dmsu_pkg::ST_LOAD;
                        overflowed_next = 1'b0;
                    end
                end
            end
            default:
            begin
                state_next = dmsu_pkg::ST_LOAD;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= dmsu_pkg::ST_LOAD;
            count_reg      <= '0;
            overflowed_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            overflowed_reg <= overflowed_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Output register takes the head cell on every pop.
    always_ff @(posedge clk)
    begin
        if (ctrl.pop)
        begin
            out_key_reg  <= dmsu_pkg::OUT_KEY_BITS'(entries[0].key);
            out_pos_reg  <= dmsu_pkg::OUT_POS_BITS'(entries[0].pos);
            out_ovf_reg  <= overflowed_reg;
            out_last_reg <= (count_reg == dmsu_pkg::CNT_BITS'(1));
        end
    end

    assign result.valid    = out_valid_reg;
    assign result.key_out  = out_key_reg;
    assign result.position = out_pos_reg;
    assign result.overflow = out_ovf_reg;
    assign result.last_out = out_last_reg;

endmodule

`default_nettype wire

FILE: design/dmsu_checker.sv
// ----------------------------------------------------------------------------
// dmsu_checker
// Port-level checks of the descending merge sorter, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "descending_merge_sorter_unit_macros.svh"

module dmsu_checker (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              load_valid,
    input  wire logic                              load_ready,
    input  wire logic                              load_last,
    input  wire logic                              res_valid,
    input  wire logic                              res_ready,
    input  wire logic [dmsu_pkg::OUT_KEY_BITS-1:0] res_key,
    input  wire logic [dmsu_pkg::OUT_POS_BITS-1:0] res_pos,
    input  wire logic                              res_last
);

    logic                              res_acc;
    logic                              in_set_reg;
    logic [dmsu_pkg::OUT_KEY_BITS-1:0] prev_key_reg;
    logic [dmsu_pkg::OUT_POS_BITS-1:0] prev_pos_reg;

    assign res_acc = res_valid && res_ready;

    // Track whether the previous accepted result belongs to the same set.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_set_reg <= 1'b0;
        end
        else if (res_acc)
        begin
            in_set_reg <= !res_last;
        end
    end

    // Last accepted result of the current set.
    always_ff @(posedge clk)
    begin
        if (res_acc)
        begin
            prev_key_reg <= res_key;
            prev_pos_reg <= res_pos;
        end
    end

    // A stalled result holds its payload.
    `DMSU_ASSERT_NEXT(a_res_hold, clk, rst_n, res_valid && !res_ready,
        res_valid && $stable(res_key) && $stable(res_pos) && $stable(res_last))

    // The item that closes a set stops loading while the set drains.
    `DMSU_ASSERT_NEXT(a_last_stops_load, clk, rst_n,
        load_valid && load_ready && load_last, !load_ready)

    // Results of one set come out largest key first, later arrival first.
    `DMSU_ASSERT_IMPLY(a_descending, clk, rst_n, res_acc && in_set_reg,
        (res_key < prev_key_reg) || ((res_key == prev_key_reg) && (res_pos < prev_pos_reg)))

endmodule

bind descending_merge_sorter_unit dmsu_checker u_dmsu_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .load_valid (load.valid),
    .load_ready (load.ready),
    .load_last  (load.last),
    .res_valid  (result.valid),
    .res_ready  (result.ready),
    .res_key    (result.key_out),
    .res_pos    (result.position),
    .res_last   (result.last_out)
);

`default_nettype wire
